### rtl/core/lbt_pkg.sv
// Shared types and constants for the LRU block key tracker.
`default_nettype none
package lbt_pkg;

  localparam int ENTRIES   = 64;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = IDX_W + 1;
  localparam int RANK_W    = IDX_W;
  localparam int COORD_W   = 16;
  localparam int KEY_W     = 3 * COORD_W;
  localparam int CAP_W     = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(ENTRIES);
  localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(ENTRIES);

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [RANK_W-1:0] rank;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

### rtl/core/lbt_ram.sv
// Key and recency store: one write port, one read port, registered read data.
`default_nettype none
module lbt_ram (
  input  wire logic                 clk,
  input  wire logic                 rd_en,
  input  wire logic [lbt_pkg::IDX_W-1:0] rd_addr,
  output lbt_pkg::entry_t           rd_data,
  input  wire logic                 wr_en,
  input  wire logic [lbt_pkg::IDX_W-1:0] wr_addr,
  input  wire lbt_pkg::entry_t      wr_data
);
  import lbt_pkg::*;

  entry_t mem [ENTRIES];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### rtl/core/lru_block_tracker_evict.sv
// Top level of the fully associative LRU tracker for map block keys.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_stall   | in_key_x, in_key_y, in_key_z
//   out_    | output    | out_valid / out_stall | out_hit, out_evicted, out_evict_x/y/z
//   cfg_    | input     | cfg_we                | cfg_wdata (capacity)
//
// Each transaction runs a scan pass over all 64 store entries: a read of each entry through the
// single read port, then a decision once the last read data is in. A hit or an insert (into a
// free slot or in place of the least recent entry) adds an update pass over all entries, and
// the result then loads the output register once it is free; in_stall stays high until then,
// so a new transaction is taken only after the last one has loaded its result.
// Reset clears valid bits, held count and capacity (back to 64) at once; a stalled result
// waits in the output register while the next input transaction is accepted and processed.
`default_nettype none
module lru_block_tracker_evict (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_key_x,
  input  wire logic signed [15:0] in_key_y,
  input  wire logic signed [15:0] in_key_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_hit,
  output logic                    out_evicted,
  output logic signed [15:0]      out_evict_x,
  output logic signed [15:0]      out_evict_y,
  output logic signed [15:0]      out_evict_z,
  input  wire logic               cfg_we,
  input  wire logic [lbt_pkg::CAP_W-1:0] cfg_wdata
);
  import lbt_pkg::*;

  // Control state.
  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 pend_r, pend_nxt;
  logic [IDX_W-1:0]     pidx_r, pidx_nxt;
  logic [ENTRIES-1:0]   valid_r, valid_nxt;
  logic [CAP_W-1:0]     held_r, held_nxt;
  logic [CAP_W-1:0]     cap_r;
  logic                 out_valid_r, out_valid_nxt;

  // Scan results and transaction payload.
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     slot_r, slot_nxt;
  logic [RANK_W-1:0]    hrank_r, hrank_nxt;
  logic                 have_lru_r, have_lru_nxt;
  logic [IDX_W-1:0]     lru_r, lru_nxt;
  logic [RANK_W-1:0]    lru_rank_r, lru_rank_nxt;
  logic [KEY_W-1:0]     lru_key_r, lru_key_nxt;
  logic                 have_free_r, have_free_nxt;
  logic [IDX_W-1:0]     free_r, free_nxt;
  logic                 res_hit_r, res_hit_nxt;
  logic                 res_ev_r, res_ev_nxt;
  logic [KEY_W-1:0]     res_key_r, res_key_nxt;
  logic                 out_hit_r, out_hit_nxt;
  logic                 out_ev_r, out_ev_nxt;
  logic [KEY_W-1:0]     out_key_r, out_key_nxt;

  // Store port signals.
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  entry_t               rd_data;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  entry_t               wr_data;
  logic [CAP_W-1:0]     cap_eff;

  lbt_ram u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Capacities above the store depth behave as the full store.
  assign cap_eff = (cap_r > CAP_MAX) ? CAP_MAX : cap_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = 1'b0;
    pidx_nxt      = cnt_r[IDX_W-1:0];
    valid_nxt     = valid_r;
    held_nxt      = held_r;
    out_valid_nxt = out_valid_r;
    key_nxt       = key_r;
    found_nxt     = found_r;
    slot_nxt      = slot_r;
    hrank_nxt     = hrank_r;
    have_lru_nxt  = have_lru_r;
    lru_nxt       = lru_r;
    lru_rank_nxt  = lru_rank_r;
    lru_key_nxt   = lru_key_r;
    have_free_nxt = have_free_r;
    free_nxt      = free_r;
    res_hit_nxt   = res_hit_r;
    res_ev_nxt    = res_ev_r;
    res_key_nxt   = res_key_r;
    out_hit_nxt   = out_hit_r;
    out_ev_nxt    = out_ev_r;
    out_key_nxt   = out_key_r;
    rd_en         = 1'b0;
    rd_addr       = cnt_r[IDX_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = pidx_r;
    wr_data       = '0;
    in_stall      = (state_r != ST_IDLE);

    // The downstream side takes the waiting result.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          key_nxt       = {in_key_z, in_key_y, in_key_x};
          found_nxt     = 1'b0;
          have_lru_nxt  = 1'b0;
          have_free_nxt = 1'b0;
          res_hit_nxt   = 1'b0;
          res_ev_nxt    = 1'b0;
          res_key_nxt   = '0;
          cnt_nxt       = '0;
          state_nxt     = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle; the data comes back in the next cycle.
        if (!cnt_r[CNT_W-1]) begin
          rd_en    = 1'b1;
          cnt_nxt  = cnt_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          if (valid_r[pidx_r]) begin
            if (!found_r && rd_data.key == key_r) begin
              found_nxt = 1'b1;
              slot_nxt  = pidx_r;
              hrank_nxt = rd_data.rank;
            end
            if (!have_lru_r || rd_data.rank > lru_rank_r) begin
              have_lru_nxt = 1'b1;
              lru_nxt      = pidx_r;
              lru_rank_nxt = rd_data.rank;
              lru_key_nxt  = rd_data.key;
            end
          end else if (!have_free_r) begin
            have_free_nxt = 1'b1;
            free_nxt      = pidx_r;
          end
        end
        if (cnt_r[CNT_W-1] && !pend_r) begin
          cnt_nxt = '0;
          if (found_r) begin
            // Hit: move the entry to the front.
            res_hit_nxt = 1'b1;
            state_nxt   = ST_UPD;
          end else if (held_r >= cap_eff) begin
            res_ev_nxt = 1'b1;
            if (!have_lru_r) begin
              // Nothing held and no room: the new key leaves at once.
              res_key_nxt = key_r;
              state_nxt   = ST_DONE;
            end else begin
              // Replace the least recent entry in place.
              res_key_nxt = lru_key_r;
              slot_nxt    = lru_r;
              state_nxt   = ST_UPD;
            end
          end else if (have_free_r) begin
            slot_nxt            = free_r;
            valid_nxt[free_r]   = 1'b1;
            held_nxt            = held_r + CAP_W'(1);
            state_nxt           = ST_UPD;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end

      ST_UPD: begin
        // Second pass: read each entry, then write back those whose rank changes.
        if (!cnt_r[CNT_W-1]) begin
          rd_en    = 1'b1;
          cnt_nxt  = cnt_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          if (pidx_r == slot_r) begin
            wr_en        = 1'b1;
            wr_data.key  = found_r ? rd_data.key : key_r;
            wr_data.rank = '0;
          end else if (valid_r[pidx_r] && (!found_r || rd_data.rank < hrank_r)) begin
            wr_en        = 1'b1;
            wr_data.key  = rd_data.key;
            wr_data.rank = rd_data.rank + RANK_W'(1);
          end
        end
        if (cnt_r[CNT_W-1] && !pend_r) begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_ev_nxt    = res_ev_r;
          out_key_nxt   = res_key_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      valid_r     <= '0;
      held_r      <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      valid_r     <= valid_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx_r      <= pidx_nxt;
    key_r       <= key_nxt;
    found_r     <= found_nxt;
    slot_r      <= slot_nxt;
    hrank_r     <= hrank_nxt;
    have_lru_r  <= have_lru_nxt;
    lru_r       <= lru_nxt;
    lru_rank_r  <= lru_rank_nxt;
    lru_key_r   <= lru_key_nxt;
    have_free_r <= have_free_nxt;
    free_r      <= free_nxt;
    res_hit_r   <= res_hit_nxt;
    res_ev_r    <= res_ev_nxt;
    res_key_r   <= res_key_nxt;
    out_hit_r   <= out_hit_nxt;
    out_ev_r    <= out_ev_nxt;
    out_key_r   <= out_key_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_evicted = out_ev_r;
  assign out_evict_x = out_key_r[COORD_W-1:0];
  assign out_evict_y = out_key_r[2*COORD_W-1:COORD_W];
  assign out_evict_z = out_key_r[3*COORD_W-1:2*COORD_W];

endmodule
`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the LRU block key tracker with eviction reporting.
module testbench;
  import lbt_pkg::*;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  // Block ports, all driven to known values from time zero.
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [15:0]      in_key_x = '0;
  logic signed [15:0]      in_key_y = '0;
  logic signed [15:0]      in_key_z = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_hit;
  logic                    out_evicted;
  logic signed [15:0]      out_evict_x;
  logic signed [15:0]      out_evict_y;
  logic signed [15:0]      out_evict_z;
  logic                    cfg_we = 1'b0;
  logic [CAP_W-1:0]        cfg_wdata = '0;

  lru_block_tracker_evict DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_key_x(in_key_x), .in_key_y(in_key_y), .in_key_z(in_key_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_hit(out_hit), .out_evicted(out_evicted),
    .out_evict_x(out_evict_x), .out_evict_y(out_evict_y), .out_evict_z(out_evict_z),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // One block key and one tracker outcome.
  typedef struct packed {
    logic [15:0] z;
    logic [15:0] y;
    logic [15:0] x;
  } block_key_t;

  typedef struct packed {
    logic        hit;
    logic        evicted;
    block_key_t  victim;
  } outcome_t;

  // Shadow copy of the tracker: keys, valid bits, recency ranks (0 = most recent).
  block_key_t       shadow_key[ENTRIES];
  logic             shadow_valid[ENTRIES];
  int unsigned      shadow_rank[ENTRIES];
  int unsigned      shadow_held;
  int unsigned      shadow_capacity;

  block_key_t       pending_keys[$];   // keys waiting for the driver
  outcome_t         expected_outcomes[$];
  int               error_count = 0;
  bit               sender_paused = 1'b0;
  bit               long_hold_req = 1'b0;
  int               long_hold_left = 0;
  longint           cycle_count = 0;

  // Appends one key to the driver's queue.
  task automatic add_key(block_key_t k);
    pending_keys = {pending_keys, k};
  endtask

  // Applies one key to the shadow tracker and returns the outcome the block should give.
  function automatic outcome_t track_key(block_key_t k);
    outcome_t    res;
    int          hit_slot;
    int          lru_slot;
    int unsigned lru_rank;
    int unsigned cap;
    int          slot;
    res = '0;
    hit_slot = -1;
    lru_slot = -1;
    lru_rank = 0;
    cap = (shadow_capacity > ENTRIES) ? ENTRIES : shadow_capacity;
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_valid[i]) begin
        if (hit_slot < 0 && shadow_key[i] == k) hit_slot = i;
        if (lru_slot < 0 || shadow_rank[i] > lru_rank) begin
          lru_slot = i;
          lru_rank = shadow_rank[i];
        end
      end
    end
    if (hit_slot >= 0) begin
      for (int i = 0; i < ENTRIES; i++)
        if (shadow_valid[i] && shadow_rank[i] < shadow_rank[hit_slot]) shadow_rank[i]++;
      shadow_rank[hit_slot] = 0;
      res.hit = 1'b1;
      return res;
    end
    slot = -1;
    if (shadow_held + 1 > cap) begin
      res.evicted = 1'b1;
      // With capacity zero and nothing held, the new key bounces straight out.
      if (lru_slot < 0) begin
        res.victim = k;
        return res;
      end
      res.victim = shadow_key[lru_slot];
      shadow_valid[lru_slot] = 1'b0;
      shadow_held--;
      slot = lru_slot;
    end else begin
      for (int i = ENTRIES - 1; i >= 0; i--)
        if (!shadow_valid[i]) slot = i;
      if (slot < 0) return res;
    end
    for (int i = 0; i < ENTRIES; i++)
      if (shadow_valid[i]) shadow_rank[i]++;
    shadow_valid[slot] = 1'b1;
    shadow_key[slot] = k;
    shadow_rank[slot] = 0;
    shadow_held++;
    return res;
  endfunction

  // Random gap length: mostly zero or short, sometimes long.
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  // Keys from a small pool give many hits; fully random keys exercise every bit.
  block_key_t key_pool[80];
  function automatic block_key_t random_key(int pool_size);
    block_key_t k;
    if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, pool_size - 1)];
    k = {16'($urandom), 16'($urandom), 16'($urandom)};
    return k;
  endfunction

  // Driver: presents queued keys, predicts each one when it is accepted.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_outcomes = {expected_outcomes, track_key({in_key_z, in_key_y, in_key_x})};
        void'(pending_keys.pop_front());
        send_gap = pick_gap();
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_keys.size() > 0 && !sender_paused) begin
          in_valid <= 1'b1;
          in_key_x <= pending_keys[0].x;
          in_key_y <= pending_keys[0].y;
          in_key_z <= pending_keys[0].z;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random short gaps, plus one long hold on request.
  int stall_gap = 0;
  always @(posedge clk) begin
    if (long_hold_req && long_hold_left == 0) long_hold_left = 3000;
    if (long_hold_left > 0) begin
      long_hold_left = long_hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_gap > 0) begin
      stall_gap = stall_gap - 1;
      out_stall <= 1'b1;
    end else begin
      stall_gap = pick_gap();
      out_stall <= (stall_gap > 0);
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_hit, out_evicted, out_evict_z, out_evict_y, out_evict_x};
      if (expected_outcomes.size() == 0) begin
        $display("%0t: result expected none actual %h", $time, got);
        error_count++;
      end else begin
        want = expected_outcomes.pop_front();
        if (got.hit !== want.hit)
          $display("%0t: hit expected %b actual %b", $time, want.hit, got.hit);
        if (got.evicted !== want.evicted)
          $display("%0t: evicted expected %b actual %b", $time, want.evicted, got.evicted);
        if (got.victim.x !== want.victim.x)
          $display("%0t: evict_x expected %h actual %h", $time, want.victim.x, got.victim.x);
        if (got.victim.y !== want.victim.y)
          $display("%0t: evict_y expected %h actual %h", $time, want.victim.y, got.victim.y);
        if (got.victim.z !== want.victim.z)
          $display("%0t: evict_z expected %h actual %h", $time, want.victim.z, got.victim.z);
        if (got !== want) error_count++;
      end
    end
  end

  // Watchdog on the total cycle count.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 2000000) begin
      $display("** lru_block_tracker_evict: FAILED **");
      $finish;
    end
  end

  // Waits until all queued keys are sent and answered, then lets the block settle.
  task automatic drain();
    while (pending_keys.size() > 0 || expected_outcomes.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Writes the capacity register while the block is idle.
  task automatic set_capacity(int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= CAP_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_capacity = value & 'h7F;
  endtask

  // Queues a burst of random keys from the first pool_size pool entries.
  task automatic queue_random(int count, int pool_size);
    for (int i = 0; i < count; i++) add_key(random_key(pool_size));
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_key[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_rank[i] = 0;
    end
    shadow_held = 0;
    shadow_capacity = ENTRIES;
    for (int i = 0; i < 80; i++)
      key_pool[i] = {16'($urandom), 16'($urandom), 16'($urandom)};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: coordinate extremes, repeat hits, then capacity one and zero.
    add_key({16'h0000, 16'h0000, 16'h0000});
    add_key({16'h7FFF, 16'h7FFF, 16'h7FFF});
    add_key({16'h8000, 16'h8000, 16'h8000});
    add_key({16'hFFFF, 16'hFFFF, 16'hFFFF});
    add_key({16'h0000, 16'h0000, 16'h0000});
    add_key({16'h8000, 16'h7FFF, 16'hFFFF});
    add_key({16'hFFFF, 16'hFFFF, 16'hFFFF});
    drain();
    // Capacity lowered below the held count: each miss evicts only one key.
    set_capacity(1);
    add_key({16'h0001, 16'h0002, 16'h0003});
    add_key({16'h0001, 16'h0002, 16'h0003});
    add_key({16'h0004, 16'h0005, 16'h0006});
    add_key({16'h0004, 16'h0005, 16'h0006});
    drain();
    // Capacity zero with keys still held: each miss evicts the least recent key in its place.
    set_capacity(0);
    add_key({16'h1111, 16'h2222, 16'h3333});
    add_key({16'h1111, 16'h2222, 16'h3333});
    add_key({16'hAAAA, 16'h5555, 16'hAAAA});
    drain();
    // Capacity above the store size saturates.
    set_capacity(127);
    queue_random(30, 80);
    drain();

    // Random phases at several capacities. The receiver holds off for a long stretch
    // during the first one so the block backs up onto its input.
    set_capacity(4);
    long_hold_req = 1'b1;
    queue_random(120, 8);
    repeat (10) @(posedge clk);
    long_hold_req = 1'b0;
    drain();
    set_capacity(64);
    queue_random(150, 80);
    drain();
    set_capacity(16);
    queue_random(120, 24);
    // Sender pauses midway until every outstanding result has come back.
    while (pending_keys.size() > 60) @(posedge clk);
    sender_paused = 1'b1;
    while (expected_outcomes.size() > 0 || in_valid) @(posedge clk);
    sender_paused = 1'b0;
    drain();
    set_capacity(1);
    queue_random(60, 3);
    drain();
    set_capacity(65);
    queue_random(100, 80);
    drain();
    set_capacity(33);
    queue_random(60, 40);
    drain();

    if (error_count == 0) begin
      $display("** lru_block_tracker_evict: PASSED **");
    end else begin
      $display("** lru_block_tracker_evict: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/lbt_pkg.sv
rtl/core/lbt_ram.sv
rtl/core/lru_block_tracker_evict.sv
sim/testbench.sv
